// ----- sv/mbps_pkg.sv -----
package mbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 32;
    localparam int BYTE_W      = 8;
    localparam int OUT_W       = 32;
    localparam int CFG_W       = 64;
    localparam int WILD_W      = 16;
    localparam int LEN_W       = 5;
    localparam int WIN_DEPTH   = MAX_PATTERN - 1;
    localparam int CLAMP_W     = $clog2(MAX_PATTERN + 1);
    localparam int AGE_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int REG_IDX_W   = 2;
    localparam int ADDR_W      = REG_IDX_W + 3;

    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam int RDEPTH      = 2;
    localparam int RPTR_W      = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
    localparam int RCNT_W      = $clog2(RDEPTH + 1);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PAT_FIRST  = 2'd0,
        REG_PAT_SECOND = 2'd1,
        REG_WILDCARD   = 2'd2,
        REG_LENGTH     = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0]  pat_first;
        logic [CFG_W-1:0]  pat_second;
        logic [WILD_W-1:0] wild;
        logic [LEN_W-1:0]  length;
    } cfg_t;

    typedef struct packed {
        logic [MAX_PATTERN-1:0][BYTE_W-1:0] window;
        logic [OFFSET_BITS-1:0]             count;
        logic                               last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic             found;
        logic [OUT_W-1:0] offset;
    } result_t;

endpackage

// ----- sv/mbps_front.sv -----
module mbps_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic [mbps_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          region_end,
    output logic                          q_push,
    output mbps_pkg::item_t               q_item
);

    logic [mbps_pkg::WIN_DEPTH-1:0][mbps_pkg::BYTE_W-1:0] window_reg;
    logic [mbps_pkg::WIN_DEPTH-1:0][mbps_pkg::BYTE_W-1:0] window_next;
    logic [mbps_pkg::OFFSET_BITS-1:0]                     seen_reg;
    logic [mbps_pkg::OFFSET_BITS-1:0]                     seen_next;
    logic [mbps_pkg::OFFSET_BITS-1:0]                     count;

    assign q_push = push && !full;

    // saturate at the offset limit
    assign count = (&seen_reg) ? seen_reg : seen_reg + mbps_pkg::OFFSET_BITS'(1);

    always_comb
    begin
        q_item.window[0] = data_byte;
        for (int a = 1; a < mbps_pkg::MAX_PATTERN; a++)
        begin
            q_item.window[a] = window_reg[a-1];
        end
        q_item.count = count;
        q_item.last  = region_end;
    end

    always_comb
    begin
        window_next = window_reg;
        seen_next   = seen_reg;
        if (q_push)
        begin
            window_next[0] = data_byte;
            for (int a = 1; a < mbps_pkg::WIN_DEPTH; a++)
            begin
                window_next[a] = window_reg[a-1];
            end
            seen_next = region_end ? '0 : count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            window_reg <= window_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

// ----- sv/mbps_queue.sv -----
module mbps_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_push,
    input  mbps_pkg::item_t       q_item,
    input  logic                  take,
    output logic                  full,
    output mbps_pkg::queue_head_t head
);

    mbps_pkg::item_t                  mem_reg [mbps_pkg::QDEPTH];
    logic [mbps_pkg::QPTR_W-1:0]      wr_reg;
    logic [mbps_pkg::QPTR_W-1:0]      wr_next;
    logic [mbps_pkg::QPTR_W-1:0]      rd_reg;
    logic [mbps_pkg::QPTR_W-1:0]      rd_next;
    logic [mbps_pkg::QCNT_W-1:0]      cnt_reg;
    logic [mbps_pkg::QCNT_W-1:0]      cnt_next;
    logic                             do_pop;

    assign full       = (cnt_reg == mbps_pkg::QCNT_W'(mbps_pkg::QDEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.item  = mem_reg[rd_reg];
    assign do_pop     = take && head.valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (q_push)
        begin
            wr_next = (wr_reg == mbps_pkg::QPTR_W'(mbps_pkg::QDEPTH - 1)) ? '0
                    : wr_reg + mbps_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == mbps_pkg::QPTR_W'(mbps_pkg::QDEPTH - 1)) ? '0
                    : rd_reg + mbps_pkg::QPTR_W'(1);
        end
        if (q_push && !do_pop)
        begin
            cnt_next = cnt_reg + mbps_pkg::QCNT_W'(1);
        end
        else if (do_pop && !q_push)
        begin
            cnt_next = cnt_reg - mbps_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            mem_reg[wr_reg] <= q_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- sv/mbps_back.sv -----
module mbps_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mbps_pkg::cfg_t                cfg,
    input  mbps_pkg::queue_head_t         head,
    output logic                          take,
    input  logic                          pop,
    output logic                          empty,
    output logic                          found,
    output logic [mbps_pkg::OUT_W-1:0]    match_offset
);

    logic [mbps_pkg::CLAMP_W-1:0]         len;
    logic [mbps_pkg::MAX_PATTERN-1:0]     pos_ok;
    logic                                 hit;
    logic [mbps_pkg::OFFSET_BITS-1:0]     start;
    logic                                 emit;
    mbps_pkg::result_t                    res_in;
    logic                                 reported_reg;
    logic                                 reported_next;

    mbps_pkg::result_t                    res_reg [mbps_pkg::RDEPTH];
    logic [mbps_pkg::RPTR_W-1:0]          wr_reg;
    logic [mbps_pkg::RPTR_W-1:0]          wr_next;
    logic [mbps_pkg::RPTR_W-1:0]          rd_reg;
    logic [mbps_pkg::RPTR_W-1:0]          rd_next;
    logic [mbps_pkg::RCNT_W-1:0]          cnt_reg;
    logic [mbps_pkg::RCNT_W-1:0]          cnt_next;
    logic                                 do_pop;

    always_comb
    begin
        if (32'(cfg.length) > 32'(mbps_pkg::MAX_PATTERN))
        begin
            len = mbps_pkg::CLAMP_W'(mbps_pkg::MAX_PATTERN);
        end
        else
        begin
            len = mbps_pkg::CLAMP_W'(cfg.length);
        end
    end

    for (genvar j = 0; j < mbps_pkg::MAX_PATTERN; j++)
    begin : g_pos
        logic [mbps_pkg::AGE_W-1:0]  age;
        logic [mbps_pkg::BYTE_W-1:0] pbyte;
        logic                        wild;

        assign age = mbps_pkg::AGE_W'(len - mbps_pkg::CLAMP_W'(j) - mbps_pkg::CLAMP_W'(1));

        if (j < 8)
        begin : g_first
            assign pbyte = cfg.pat_first[8*j +: 8];
        end
        else if (j < 16)
        begin : g_second
            assign pbyte = cfg.pat_second[8*(j-8) +: 8];
        end
        else
        begin : g_none
            assign pbyte = '0;
        end

        if (j < mbps_pkg::WILD_W)
        begin : g_wild
            assign wild = cfg.wild[j];
        end
        else
        begin : g_tame
            assign wild = 1'b0;
        end

        assign pos_ok[j] = (mbps_pkg::CLAMP_W'(j) >= len) || wild
                         || (pbyte == head.item.window[age]);
    end

    assign hit   = (len == '0)
                || ((head.item.count >= mbps_pkg::OFFSET_BITS'(len)) && (&pos_ok));
    assign start = (len == '0) ? '0 : head.item.count - mbps_pkg::OFFSET_BITS'(len);

    assign take  = head.valid && (cnt_reg != mbps_pkg::RCNT_W'(mbps_pkg::RDEPTH));
    assign emit  = take && !reported_reg && (hit || head.item.last);

    assign res_in.found  = hit;
    assign res_in.offset = hit ? mbps_pkg::OUT_W'(start) : '0;

    assign empty        = (cnt_reg == '0);
    assign found        = res_reg[rd_reg].found;
    assign match_offset = res_reg[rd_reg].offset;
    assign do_pop       = pop && !empty;

    always_comb
    begin
        reported_next = reported_reg;
        if (take)
        begin
            if (head.item.last)
            begin
                reported_next = 1'b0;
            end
            else if (hit)
            begin
                reported_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (emit)
        begin
            wr_next = (wr_reg == mbps_pkg::RPTR_W'(mbps_pkg::RDEPTH - 1)) ? '0
                    : wr_reg + mbps_pkg::RPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == mbps_pkg::RPTR_W'(mbps_pkg::RDEPTH - 1)) ? '0
                    : rd_reg + mbps_pkg::RPTR_W'(1);
        end
        if (emit && !do_pop)
        begin
            cnt_next = cnt_reg + mbps_pkg::RCNT_W'(1);
        end
        else if (do_pop && !emit)
        begin
            cnt_next = cnt_reg - mbps_pkg::RCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg[wr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg <= 1'b0;
            wr_reg       <= '0;
            rd_reg       <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            reported_reg <= reported_next;
            wr_reg       <= wr_next;
            rd_reg       <= rd_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

// ----- sv/masked_byte_pattern_scan_unit.sv -----
// Masked byte pattern scan.
// Input queue side: data_byte and region_end are taken at a clock edge with push high
// and full low; region_end marks the last byte of a region.
// Result queue side: while empty is low the oldest result stands on found and
// match_offset; pop with empty low takes it. Each region gives one result: found with
// the start offset of the first match, or found low with offset 0 on its last byte.
// A request that yields a result is written into the middle queue; the back takes it
// from there and writes the result into the result queue, unless that queue is full.
// Throughput: one byte per cycle while full is low; all pattern positions are compared
// in parallel in the back stage, and a two-entry queue sits between front and back.
// If the result side stalls, the result queue fills, the back stops draining the
// middle queue, and full rises once that queue is full; nothing is lost.
// Configuration is an APB-style port with 64-bit registers at byte addresses 0, 8,
// 16 and 24; write it only while the block is idle.
// Reset clears the byte count, both queues and the registers (pattern length to one).
module masked_byte_pattern_scan_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    data_byte,
    input  logic                          region_end,
    output logic                          empty,
    input  logic                          pop,
    output logic                          found,
    output logic [31:0]                   match_offset,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbps_pkg::ADDR_W-1:0]   paddr,
    input  logic [mbps_pkg::CFG_W-1:0]    pwdata,
    output logic [mbps_pkg::CFG_W-1:0]    prdata,
    output logic                          pready
);

    mbps_pkg::cfg_t        cfg_reg;
    mbps_pkg::cfg_t        cfg_next;
    mbps_pkg::reg_index_t  reg_index;
    mbps_pkg::item_t       q_item;
    mbps_pkg::queue_head_t head;
    logic                  q_push;
    logic                  take;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign reg_index = mbps_pkg::reg_index_t'(paddr[mbps_pkg::ADDR_W-1:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                mbps_pkg::REG_PAT_FIRST:  cfg_next.pat_first  = pwdata;
                mbps_pkg::REG_PAT_SECOND: cfg_next.pat_second = pwdata;
                mbps_pkg::REG_WILDCARD:   cfg_next.wild       = pwdata[mbps_pkg::WILD_W-1:0];
                mbps_pkg::REG_LENGTH:     cfg_next.length     = pwdata[mbps_pkg::LEN_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            mbps_pkg::REG_PAT_FIRST:  prdata = cfg_reg.pat_first;
            mbps_pkg::REG_PAT_SECOND: prdata = cfg_reg.pat_second;
            mbps_pkg::REG_WILDCARD:   prdata = mbps_pkg::CFG_W'(cfg_reg.wild);
            mbps_pkg::REG_LENGTH:     prdata = mbps_pkg::CFG_W'(cfg_reg.length);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pat_first  <= '0;
            cfg_reg.pat_second <= '0;
            cfg_reg.wild       <= '0;
            cfg_reg.length     <= mbps_pkg::LEN_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mbps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .region_end (region_end),
        .q_push     (q_push),
        .q_item     (q_item)
    );

    mbps_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_item (q_item),
        .take   (take),
        .full   (full),
        .head   (head)
    );

    mbps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .take         (take),
        .pop          (pop),
        .empty        (empty),
        .found        (found),
        .match_offset (match_offset)
    );

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !found) |-> (match_offset == '0))
        else $error("not-found result with nonzero offset");

    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> head.valid)
        else $error("middle queue full without a valid head");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !head.valid) |=> empty)
        else $error("result appeared with no request in flight");

endmodule

// ----- bench/tb_masked_byte_pattern_scan_unit.sv -----
module tb_masked_byte_pattern_scan_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          HOLD_CYCLES     = 80;
    localparam int          NUM_PHASES      = 10;
    localparam int          ITEMS_PER_PHASE = 85;
    localparam longint unsigned COUNT_LIMIT = (64'd1 << mbps_pkg::OFFSET_BITS) - 64'd1;
    localparam int          PHASE_LEN [NUM_PHASES] = '{1, 16, 0, 31, 2, 17, 5, 12, 3, 8};

    typedef struct packed {
        logic [2:0]  cfg_sel;
        logic [7:0]  b;
        logic        last;
        logic        fixed;
        logic        exp_n;
        logic        exp_found;
        logic [31:0] exp_off;
    } scan_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        push = 1'b0;
    logic                        full;
    logic [7:0]                  data_byte = '0;
    logic                        region_end = 1'b0;
    logic                        empty;
    logic                        pop = 1'b0;
    logic                        found;
    logic [31:0]                 match_offset;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [mbps_pkg::ADDR_W-1:0] paddr = '0;
    logic [mbps_pkg::CFG_W-1:0]  pwdata = '0;
    logic [mbps_pkg::CFG_W-1:0]  prdata;
    logic                        pready;

    mbps_pkg::cfg_t    pred_cfg = '{pat_first: '0, pat_second: '0, wild: '0, length: 5'd1};
    logic [7:0]        scan_hist [mbps_pkg::WIN_DEPTH];
    longint unsigned   scan_seen = 0;
    bit                scan_reported = 1'b0;

    mbps_pkg::result_t pending_results [$];
    int                mismatches = 0;
    int                cycles = 0;

    logic              row_fixed = 1'b0;
    logic              row_exp_n = 1'b0;
    mbps_pkg::result_t row_exp = '0;

    int                burst_left = 0;
    bit                no_gaps = 1'b0;
    int                hold_asked = 0;
    int                hold_served = 0;
    int                rx_hold = 0;
    int                rx_tick = 0;
    int                rx_mode = 0;
    logic [7:0]        region_q [$];

    mbps_pkg::cfg_t dir_cfgs [5] = '{
        '{64'h0, 64'h0, 16'h0000, 5'd1},
        '{64'h0, 64'h0, 16'h0000, 5'd0},
        '{64'h0, 64'h0, 16'hFFFF, 5'd31},
        '{64'h34EE12, 64'h0, 16'h0002, 5'd3},
        '{64'h00FF, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 5'd2}
    };

    scan_row_t dir_rows [22] = '{
        '{3'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0},
        '{3'd0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
        '{3'd0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
        '{3'd0, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0},
        '{3'd0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 32'd1},
        '{3'd1, 8'hAB, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0},
        '{3'd1, 8'h5A, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
        '{3'd2, 8'h11, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{3'd2, 8'h22, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
        '{3'd3, 8'h12, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{3'd3, 8'h99, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{3'd3, 8'h34, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0},
        '{3'd3, 8'h12, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
        '{3'd3, 8'h12, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{3'd3, 8'h34, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
        '{3'd3, 8'h55, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{3'd3, 8'h12, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{3'd3, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{3'd3, 8'h34, 1'b1, 1'b1, 1'b1, 1'b1, 32'd1},
        '{3'd4, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{3'd4, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{3'd4, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 32'd1}
    };

    masked_byte_pattern_scan_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .region_end  (region_end),
        .empty       (empty),
        .pop         (pop),
        .found       (found),
        .match_offset(match_offset),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    function automatic int eff_len();
        return (pred_cfg.length > mbps_pkg::MAX_PATTERN) ? mbps_pkg::MAX_PATTERN
                                                         : int'(pred_cfg.length);
    endfunction

    function automatic logic [7:0] pat_at(input int j);
        if (j < 8)
            return pred_cfg.pat_first[8*j +: 8];
        if (j < 16)
            return pred_cfg.pat_second[8*(j-8) +: 8];
        return 8'h00;
    endfunction

    function automatic bit wild_at(input int j);
        return (j < 16) ? pred_cfg.wild[j] : 1'b0;
    endfunction

    task automatic predict_scan(input logic [7:0] b, input bit last,
                                output bit has, output mbps_pkg::result_t res);
        int              n;
        int              age;
        longint unsigned cnt;
        longint unsigned start;
        bit              hit;
        logic [7:0]      w;
        n     = eff_len();
        cnt   = (scan_seen < COUNT_LIMIT) ? scan_seen + 1 : COUNT_LIMIT;
        has   = 1'b0;
        res   = '0;
        start = 0;
        if (!scan_reported)
        begin
            hit = 1'b0;
            if (n == 0)
            begin
                hit = 1'b1;
            end
            else if (cnt >= longint'(n))
            begin
                hit = 1'b1;
                for (int j = 0; j < n; j++)
                begin
                    age = n - 1 - j;
                    w = (age == 0) ? b : scan_hist[age-1];
                    if (!wild_at(j) && pat_at(j) != w)
                        hit = 1'b0;
                end
                start = cnt - longint'(n);
            end
            if (hit)
            begin
                has           = 1'b1;
                res.found     = 1'b1;
                res.offset    = start[31:0];
                scan_reported = 1'b1;
            end
            else if (last)
            begin
                has = 1'b1;
            end
        end
        for (int k = mbps_pkg::WIN_DEPTH - 1; k > 0; k--)
            scan_hist[k] = scan_hist[k-1];
        scan_hist[0] = b;
        scan_seen = cnt;
        if (last)
        begin
            scan_seen     = 0;
            scan_reported = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        bit                has;
        mbps_pkg::result_t res;
        mbps_pkg::result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        if (rst_n)
        begin
            if (push && !full)
            begin
                predict_scan(data_byte, region_end, has, res);
                if (row_fixed)
                begin
                    if (row_exp_n)
                        pending_results.push_back(row_exp);
                end
                else if (has)
                begin
                    pending_results.push_back(res);
                end
            end
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: found=%0b offset=%0d",
                                 found, match_offset);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (found !== want.found || match_offset !== want.offset)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected found=%0b offset=%0d, ",
                                      "got found=%0b offset=%0d"},
                                     want.found, want.offset, found, match_offset);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            pop     <= 1'b0;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served <= hold_asked;
            rx_hold     <= HOLD_CYCLES;
            pop         <= 1'b0;
        end
        else
        begin
            rx_tick <= rx_tick + 1;
            if (rx_tick % 40 == 0)
                rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                2:       pop <= (rx_tick % 5 == 0);
                default: pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic apb_write(input mbps_pkg::reg_index_t r,
                             input logic [mbps_pkg::CFG_W-1:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {r, 3'b000};
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_cfg(input mbps_pkg::cfg_t c);
        pred_cfg = c;
        apb_write(mbps_pkg::REG_PAT_FIRST, c.pat_first);
        apb_write(mbps_pkg::REG_PAT_SECOND, c.pat_second);
        apb_write(mbps_pkg::REG_WILDCARD, {16'($urandom), 32'($urandom), c.wild});
        apb_write(mbps_pkg::REG_LENGTH, {27'($urandom), 32'($urandom), c.length});
    endtask

    // drop push and wait for all requests to drain
    task automatic settle();
        push = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last, input bit fixed = 1'b0,
                             input bit exp_n = 1'b0, input mbps_pkg::result_t exp = '0);
        int gap;
        if (!no_gaps && burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                push = 1'b0;
                repeat (gap)
                begin
                    data_byte  = 8'($urandom);
                    region_end = 1'($urandom);
                    @(negedge clk);
                end
            end
        end
        if (burst_left > 0)
            burst_left--;
        push       = 1'b1;
        data_byte  = b;
        region_end = last;
        row_fixed  = fixed;
        row_exp_n  = exp_n;
        row_exp    = exp;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] noise_byte();
        if (eff_len() > 0 && $urandom_range(0, 1) == 1)
            return pat_at($urandom_range(0, eff_len() - 1));
        return 8'($urandom);
    endfunction

    task automatic build_region();
        int kind;
        int pre;
        int n;
        int idx;
        region_q.delete();
        n = eff_len();
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            pre = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 5);
            repeat (pre) region_q.push_back(noise_byte());
            for (int j = 0; j < n; j++)
                region_q.push_back(wild_at(j) ? 8'($urandom) : pat_at(j));
            // break one position of the embedded pattern
            if (kind >= 5 && n > 0)
            begin
                idx = pre + $urandom_range(0, n - 1);
                region_q[idx] = region_q[idx] ^ (8'd1 << $urandom_range(0, 7));
            end
            repeat ($urandom_range(0, 4)) region_q.push_back(noise_byte());
        end
        else
        begin
            repeat ($urandom_range(1, 24)) region_q.push_back(noise_byte());
        end
        if (region_q.size() == 0)
            region_q.push_back(noise_byte());
    endtask

    initial
    begin
        mbps_pkg::cfg_t phase_cfg;
        int             sent;
        logic [2:0]     cur_sel;
        foreach (scan_hist[i])
            scan_hist[i] = 8'h00;
        cur_sel = 3'd0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg_sel != cur_sel)
            begin
                settle();
                cur_sel = dir_rows[i].cfg_sel;
                load_cfg(dir_cfgs[cur_sel]);
            end
            send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].fixed, dir_rows[i].exp_n,
                      mbps_pkg::result_t'{found: dir_rows[i].exp_found,
                                          offset: dir_rows[i].exp_off});
        end
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            phase_cfg.length     = 5'(PHASE_LEN[p]);
            phase_cfg.pat_first  = {32'($urandom), 32'($urandom)};
            phase_cfg.pat_second = {32'($urandom), 32'($urandom)};
            phase_cfg.wild       = 16'($urandom & $urandom);
            case (p)
                0:
                begin
                    phase_cfg.pat_first  = '0;
                    phase_cfg.pat_second = '0;
                    phase_cfg.wild       = '0;
                end
                1:
                begin
                    phase_cfg.pat_first  = '1;
                    phase_cfg.pat_second = '1;
                    phase_cfg.wild       = '0;
                end
                3: phase_cfg.wild = 16'hFFFF;
                6: phase_cfg.wild = 16'($urandom);
                default: ;
            endcase
            load_cfg(phase_cfg);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                build_region();
                foreach (region_q[i])
                    send_byte(region_q[i], i == region_q.size() - 1);
                sent += region_q.size();
            end
            settle();
            // hold the result side while single-byte regions keep arriving
            if (p == 3)
            begin
                hold_asked++;
                no_gaps = 1'b1;
                repeat (40) send_byte(8'($urandom), 1'b1);
                no_gaps = 1'b0;
                settle();
            end
        end

        settle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/mbps_pkg.sv
sv/mbps_front.sv
sv/mbps_queue.sv
sv/mbps_back.sv
sv/masked_byte_pattern_scan_unit.sv
bench/tb_masked_byte_pattern_scan_unit.sv
